FILE: src/linear_color_gradient_core_assert.svh
// ----------------------------------------------------------------------------
// Assertion macros for the linear color gradient core
// Shared concurrent assertion forms, clocked on the rising edge and
// disabled while the asynchronous reset is active.
// ----------------------------------------------------------------------------
`ifndef LINEAR_COLOR_GRADIENT_CORE_ASSERT_SVH
`define LINEAR_COLOR_GRADIENT_CORE_ASSERT_SVH

// A condition that must hold at every clock edge out of reset.
`define LCG_ASSERT_ALWAYS(label, clk, rst_n, expr, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (expr)) else $error(msg);

// A consequence that must follow its cause a fixed number of cycles later.
`define LCG_ASSERT_AFTER(label, clk, rst_n, ante, n, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) \
        (ante) |-> ##n (cons)) else $error(msg);

`endif

FILE: src/lcg_pkg.sv
// ----------------------------------------------------------------------------
// Linear color gradient package
// Widths, register codes and pipeline constants shared by the gradient core
// and its per-channel interpolation lanes.
// ----------------------------------------------------------------------------
`default_nettype none

package lcg_pkg;

    // Field widths.
    localparam int POS_W    = 12;
    localparam int COLOR_W  = 32;
    localparam int GLEN_W   = 13;
    localparam int CH_W     = 8;
    localparam int CHANNELS = COLOR_W / CH_W;

    // Longest gradient the datapath is sized for, and the length width it needs.
    localparam int MAX_LENGTH_DEF = 4096;
    localparam int LEN_W_DEF      = $clog2(MAX_LENGTH_DEF + 1);

    // The alpha byte of both endpoints is inverted before interpolation.
    localparam logic [COLOR_W-1:0] ALPHA_MASK = 32'hFF00_0000;

    // Reset value of the gradient length register.
    localparam logic [GLEN_W-1:0] GLEN_RESET = 13'd1;

    // One quotient bit is resolved per divider stage.
    localparam int DIV_STAGES = CH_W;

    // Lane latency: product stage, sum stage, then the divider stages.
    localparam int LANE_LAT = 2 + DIV_STAGES;

    // Configuration register indexes.
    localparam int CFG_IDX_W = 2;
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_START_COLOR = 2'd0,
        CFG_END_COLOR   = 2'd1,
        CFG_GRAD_LEN    = 2'd2
    } cfg_index_t;

endpackage

`default_nettype wire

FILE: src/linear_color_gradient_core.sv
// ----------------------------------------------------------------------------
// Linear color gradient core
// Maps a pixel position to its ARGB color between two configured endpoint
// colors, with the alpha byte inverted, using exact integer interpolation.
// ----------------------------------------------------------------------------
//
//   Channel   Signals                                      Transfer when
//   -------   ------------------------------------------   ----------------------
//   input     start, busy, position[11:0]                  start && !busy
//   result    strobe, color[31:0]                          strobe (one cycle)
//   config    cfg_valid, cfg_ready, cfg_index, cfg_data    cfg_valid && cfg_ready
//
// One position is taken every clock cycle; busy stays low.
// A color passes through one clamp stage, one product stage, one sum stage
// and the 8-stage restoring divider, each of them registered.
// Reset clears the valid bits and restores the register defaults; no
// clearing pass is needed. The result side cannot stall, so nothing waits.
// ----------------------------------------------------------------------------
`default_nettype none

`include "linear_color_gradient_core_assert.svh"

module linear_color_gradient_core #(
    parameter int MAX_LENGTH = lcg_pkg::MAX_LENGTH_DEF
) (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          start,
    output logic                               busy,
    input  wire logic [lcg_pkg::POS_W-1:0]     position,
    output logic                               strobe,
    output logic [lcg_pkg::COLOR_W-1:0]        color,
    input  wire logic                          cfg_valid,
    output logic                               cfg_ready,
    input  wire logic [lcg_pkg::CFG_IDX_W-1:0] cfg_index,
    input  wire logic [lcg_pkg::COLOR_W-1:0]   cfg_data
);

    localparam int LEN_W    = $clog2(MAX_LENGTH + 1);
    localparam int CH_W     = lcg_pkg::CH_W;
    localparam int CHANNELS = lcg_pkg::CHANNELS;
    localparam int COLOR_W  = lcg_pkg::COLOR_W;
    localparam int GLEN_W   = lcg_pkg::GLEN_W;
    localparam int TOTAL    = 1 + lcg_pkg::LANE_LAT;

    logic [COLOR_W-1:0] start_color_reg;
    logic [COLOR_W-1:0] end_color_reg;
    logic [GLEN_W-1:0]  glen_reg;

    logic               accept;
    logic               len_zero;
    logic               len_over;
    logic [LEN_W-1:0]   len_eff;
    logic [LEN_W-1:0]   x_next;
    logic [LEN_W-1:0]   rest_next;
    logic [COLOR_W-1:0] s_word;
    logic [COLOR_W-1:0] e_word;

    logic               vld_reg;
    logic [LEN_W-1:0]   x_reg;
    logic [LEN_W-1:0]   rest_reg;

    logic [CHANNELS-1:0] lane_vld;
    logic [CH_W-1:0]     lane_quo [CHANNELS];

    // Configuration writes are always taken.
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            start_color_reg <= '0;
            end_color_reg   <= '0;
            glen_reg        <= lcg_pkg::GLEN_RESET;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (lcg_pkg::cfg_index_t'(cfg_index))
                lcg_pkg::CFG_START_COLOR: start_color_reg <= cfg_data;
                lcg_pkg::CFG_END_COLOR:   end_color_reg   <= cfg_data;
                lcg_pkg::CFG_GRAD_LEN:    glen_reg        <= cfg_data[GLEN_W-1:0];
                default:                  ;
            endcase
        end
    end

    // The pipeline never backs up, so a position is taken every cycle.
    assign busy   = 1'b0;
    assign accept = start && !busy;

    // Effective length: zero acts as one, and the length saturates at the maximum.
    assign len_zero = (glen_reg == '0);
    assign len_over = (32'(glen_reg) > 32'(MAX_LENGTH));
    assign len_eff  = len_zero ? LEN_W'(1)
                    : (len_over ? LEN_W'(MAX_LENGTH) : LEN_W'(glen_reg));

    // Positions at or past the end take the last pixel of the gradient.
    assign x_next    = (32'(position) >= 32'(len_eff)) ? (len_eff - LEN_W'(1))
                                                       : LEN_W'(position);
    assign rest_next = len_eff - x_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= 1'b0;
        end
        else
        begin
            vld_reg <= accept;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            x_reg    <= x_next;
            rest_reg <= rest_next;
        end
    end

    // Endpoints with the alpha byte inverted.
    assign s_word = start_color_reg ^ lcg_pkg::ALPHA_MASK;
    assign e_word = end_color_reg ^ lcg_pkg::ALPHA_MASK;

    // One interpolation lane per channel byte.
    for (genvar c = 0; c < CHANNELS; c++)
    begin : g_lane
        lcg_lane #(
            .LEN_W (LEN_W)
        ) u_lane (
            .clk       (clk),
            .rst_n     (rst_n),
            .in_valid  (vld_reg),
            .s_byte    (s_word[c*CH_W +: CH_W]),
            .e_byte    (e_word[c*CH_W +: CH_W]),
            .x         (x_reg),
            .rest      (rest_reg),
            .len       (len_eff),
            .out_valid (lane_vld[c]),
            .quo       (lane_quo[c])
        );

        assign color[c*CH_W +: CH_W] = lane_quo[c];
    end

    assign strobe = lane_vld[0];

    // Every accepted position yields exactly one color, at a fixed latency.
    `LCG_ASSERT_AFTER(a_result_follows, clk, rst_n, accept, TOTAL, strobe,
        "accepted position did not produce a color")
    `LCG_ASSERT_AFTER(a_no_spurious, clk, rst_n, !accept, TOTAL, !strobe,
        "color produced without an accepted position")
    // All channel lanes stay in lockstep.
    `LCG_ASSERT_ALWAYS(a_lanes_aligned, clk, rst_n,
        (lane_vld == '0) || (lane_vld == '1), "channel lanes out of step")

endmodule

`default_nettype wire

FILE: src/lcg_lane.sv
// ----------------------------------------------------------------------------
// Linear color gradient interpolation lane
// Computes one channel byte as floor((s * (L - x) + e * x) / L) through a
// product stage, a sum stage and a pipelined restoring divider that resolves
// one quotient bit per stage.
// ----------------------------------------------------------------------------
`default_nettype none

module lcg_lane #(
    parameter int LEN_W = lcg_pkg::LEN_W_DEF
) (
    input  wire logic                    clk,
    input  wire logic                    rst_n,
    input  wire logic                    in_valid,
    input  wire logic [lcg_pkg::CH_W-1:0] s_byte,
    input  wire logic [lcg_pkg::CH_W-1:0] e_byte,
    input  wire logic [LEN_W-1:0]        x,
    input  wire logic [LEN_W-1:0]        rest,
    input  wire logic [LEN_W-1:0]        len,
    output logic                         out_valid,
    output logic [lcg_pkg::CH_W-1:0]     quo
);

    localparam int CH_W   = lcg_pkg::CH_W;
    localparam int NUM_W  = LEN_W + CH_W;
    localparam int STAGES = lcg_pkg::DIV_STAGES;
    localparam int LAT    = lcg_pkg::LANE_LAT;

    logic             vld_reg [LAT];
    logic [NUM_W-1:0] prod_s_reg;
    logic [NUM_W-1:0] prod_e_reg;
    logic [NUM_W-1:0] num_reg;
    logic [NUM_W-1:0] rem_reg [STAGES];
    logic [CH_W-1:0]  quo_reg [STAGES];

    // Valid bits travel alongside the data, one per stage.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < LAT; i++)
            begin
                vld_reg[i] <= 1'b0;
            end
        end
        else
        begin
            vld_reg[0] <= in_valid;
            for (int i = 1; i < LAT; i++)
            begin
                vld_reg[i] <= vld_reg[i-1];
            end
        end
    end

    // Both endpoint weights are multiplied in the first stage.
    always_ff @(posedge clk)
    begin
        if (in_valid)
        begin
            prod_s_reg <= NUM_W'(s_byte) * NUM_W'(rest);
            prod_e_reg <= NUM_W'(e_byte) * NUM_W'(x);
        end
    end

    // The numerator stays below 256 * L, so it fits the numerator width.
    always_ff @(posedge clk)
    begin
        if (vld_reg[0])
        begin
            num_reg <= prod_s_reg + prod_e_reg;
        end
    end

    // Restoring divider: stage i tries the divisor shifted by STAGES-1-i.
    for (genvar i = 0; i < STAGES; i++)
    begin : g_div
        logic [NUM_W-1:0] src_rem;
        logic [CH_W-1:0]  src_quo;
        logic [NUM_W-1:0] dsh;
        logic             take;

        if (i == 0)
        begin : g_first
            assign src_rem = num_reg;
            assign src_quo = '0;
        end
        else
        begin : g_later
            assign src_rem = rem_reg[i-1];
            assign src_quo = quo_reg[i-1];
        end

        assign dsh  = NUM_W'(len) << (STAGES - 1 - i);
        assign take = (src_rem >= dsh);

        always_ff @(posedge clk)
        begin
            if (vld_reg[1+i])
            begin
                rem_reg[i] <= take ? (src_rem - dsh) : src_rem;
                quo_reg[i] <= {src_quo[CH_W-2:0], take};
            end
        end
    end

    assign out_valid = vld_reg[LAT-1];
    assign quo       = quo_reg[STAGES-1];

endmodule

`default_nettype wire
